// File: hw/rtl/hse_pkg.sv
// Shared types and constants of the heap sort engine.
`default_nettype none

package hse_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned TallyW = 12;
  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  typedef enum logic [3:0] {
    S_LOAD,
    S_BSTART,
    S_TOPRD,
    S_XSTART,
    S_XRD0,
    S_XRD1,
    S_LD0,
    S_LD1,
    S_LD2,
    S_CMP,
    S_ERD,
    S_EOUT,
    S_EWAIT
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/hse_store.sv
// Value store: one write port and one read port with registered read data.
`default_nettype none

module hse_store
  import hse_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  wire [DataW-1:0]  wdata_i,
  input  wire [AddrW-1:0]  raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/hse_ctrl.sv
// Sequencer of the heap sort engine: load, heap build, extraction and emit.
`default_nettype none

module hse_ctrl
  import hse_pkg::*;
#(
  parameter int unsigned MaxItems = 64,
  parameter int unsigned AddrW    = $clog2(MaxItems),
  parameter int unsigned CntW     = AddrW + 1
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire [DataW-1:0]   in_value_i,
  input  wire               in_last_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [DataW-1:0]  out_value_o,
  output logic              out_last_o,
  output logic [TallyW-1:0] out_count_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic [DataW-1:0]  mem_wdata_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  wire [DataW-1:0]   mem_rdata_i
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxItems);
  localparam logic [CntW-1:0] One    = CntW'(1);

  state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   node_q, node_d;
  logic [CntW-1:0]   child_q, child_d;
  logic [CntW-1:0]   bot_q, bot_d;
  logic              build_q, build_d;
  logic [DataW-1:0]  nval_q, nval_d;
  logic [DataW-1:0]  ca_q, ca_d;
  logic [DataW-1:0]  big_q, big_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [DataW-1:0]  odata_q, odata_d;
  logic              olast_q, olast_d;

  logic [DataW-1:0] cmp_a, cmp_b;
  logic             cmp_lt;
  logic             in_fire;
  logic [CntW-1:0]  top_idx;
  logic             sift_end;

  assign cmp_lt   = $signed(cmp_a) < $signed(cmp_b);
  assign in_fire  = in_valid_i && in_ready_o;
  assign top_idx  = idx_q - One;
  assign sift_end = (state_q == S_LD0 && child_q > bot_q) || (state_q == S_CMP && !cmp_lt);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = S_BSTART;
        end
      end
      S_BSTART: state_d = (idx_q == '0) ? S_XSTART : S_TOPRD;
      S_TOPRD:  state_d = S_LD0;
      S_XSTART: state_d = (idx_q == '0) ? S_ERD : S_XRD0;
      S_XRD0:   state_d = S_XRD1;
      S_XRD1:   state_d = S_LD0;
      S_LD0:    state_d = sift_end ? (build_q ? S_BSTART : S_XSTART) : S_LD1;
      S_LD1:    state_d = S_LD2;
      S_LD2:    state_d = S_CMP;
      S_CMP:    state_d = sift_end ? (build_q ? S_BSTART : S_XSTART) : S_LD0;
      S_ERD:    state_d = S_EOUT;
      S_EOUT:   state_d = S_EWAIT;
      S_EWAIT: begin
        if (out_ready_i) begin
          state_d = olast_q ? S_LOAD : S_ERD;
        end
      end
      default:  state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    node_d      = node_q;
    child_d     = child_q;
    bot_d       = bot_q;
    build_d     = build_q;
    nval_d      = nval_q;
    ca_d        = ca_q;
    big_d       = big_q;
    tally_d     = tally_q;
    odata_d     = odata_q;
    olast_d     = olast_q;
    cmp_a       = nval_q;
    cmp_b       = big_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q[AddrW-1:0];
    mem_wdata_o = nval_q;
    mem_raddr_o = child_q[AddrW-1:0];
    in_ready_o  = (state_q == S_LOAD);
    out_valid_o = (state_q == S_EWAIT);
    case (state_q)
      S_LOAD: begin
        mem_waddr_o = cnt_q[AddrW-1:0];
        mem_wdata_o = in_value_i;
        if (in_fire && cnt_q < MaxCnt) begin
          mem_we_o = 1'b1;
          cnt_d    = cnt_q + One;
        end
        if (in_fire && in_last_i) begin
          idx_d = cnt_d >> 1;
        end
      end
      S_BSTART: begin
        if (idx_q == '0) begin
          idx_d = cnt_q - One;
        end else begin
          mem_raddr_o = top_idx[AddrW-1:0];
          node_d      = top_idx;
          child_d     = {top_idx[AddrW-1:0], 1'b1};
          bot_d       = cnt_q - One;
          build_d     = 1'b1;
        end
      end
      S_TOPRD: begin
        nval_d = mem_rdata_i;
      end
      S_XSTART: begin
        mem_raddr_o = idx_q[AddrW-1:0];
      end
      S_XRD0: begin
        nval_d      = mem_rdata_i;
        mem_raddr_o = '0;
      end
      S_XRD1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AddrW-1:0];
        mem_wdata_o = mem_rdata_i;
        node_d      = '0;
        child_d     = One;
        bot_d       = idx_q - One;
        build_d     = 1'b0;
      end
      S_LD0: begin
        if (child_q > bot_q) begin
          mem_we_o = 1'b1;
          idx_d    = idx_q - One;
        end else if (tally_q != TallyMax) begin
          tally_d = tally_q + TallyW'(1);
        end
      end
      S_LD1: begin
        mem_raddr_o = child_q[AddrW-1:0] + AddrW'(1);
        ca_d        = mem_rdata_i;
      end
      S_LD2: begin
        cmp_a = ca_q;
        cmp_b = mem_rdata_i;
        if (child_q < bot_q && cmp_lt) begin
          big_d   = mem_rdata_i;
          child_d = child_q + One;
        end else begin
          big_d = ca_q;
        end
      end
      S_CMP: begin
        mem_we_o = 1'b1;
        if (cmp_lt) begin
          mem_wdata_o = big_q;
          node_d      = child_q;
          child_d     = {child_q[AddrW-1:0], 1'b1};
        end else begin
          idx_d = idx_q - One;
        end
      end
      S_ERD: begin
        mem_raddr_o = idx_q[AddrW-1:0];
      end
      S_EOUT: begin
        odata_d = mem_rdata_i;
        olast_d = (idx_q == cnt_q - One);
      end
      S_EWAIT: begin
        if (out_ready_i) begin
          if (olast_q) begin
            cnt_d   = '0;
            tally_d = '0;
          end else begin
            idx_d = idx_q + One;
          end
        end
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      tally_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tally_q <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    node_q  <= node_d;
    child_q <= child_d;
    bot_q   <= bot_d;
    build_q <= build_d;
    nval_q  <= nval_d;
    ca_q    <= ca_d;
    big_q   <= big_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign out_value_o = odata_q;
  assign out_last_o  = olast_q;
  assign out_count_o = tally_q;

endmodule

`default_nettype wire

// File: hw/rtl/heap_sort_engine_top.sv
// Loading: one input transaction per cycle; the block is not ready while it sorts or emits.
// Sorting: each sift-down pass runs LD0, LD1, LD2 and CMP; a heap-build node first reads
// its value (BSTART, TOPRD) and an extraction step moves the root to the end (XRD0, XRD1).
// Emit: each result is read (ERD), registered (EOUT) and held (EWAIT) until the sink is
// ready; after the last result the set restarts with loading.
// Reset clears the sequencer, item count and tally; the store is not cleared.
`default_nettype none

module heap_sort_engine_top
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] value
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] sorted_value, [43:32] compare_count, zeros
  output logic        m_axis_tlast
);

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [DataW-1:0]  mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [DataW-1:0]  mem_rdata;
  logic [DataW-1:0]  out_value;
  logic [TallyW-1:0] out_count;

  hse_store #(
    .Depth (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hse_ctrl #(
    .MaxItems (MAX_ITEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_count_o (out_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign m_axis_tdata = {4'b0000, out_count, out_value};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is presented");

  a_last_in_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("ready held after the last input transaction");

  a_last_out_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after the final result transaction");

endmodule

`default_nettype wire
